// ----- rtl/nct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor cache table package
// Shared types, codes and constants for the neighbor cache table.
// ----------------------------------------------------------------------------
package nct_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam logic [15:0] MAX_AGE_RESET = 16'd1200;
   localparam int ENTRY_W = 64 + 64 + 48 + 32;

   typedef enum logic [2:0] {
      MODE_SET_BY_IP = 3'd0,
      MODE_ADD       = 3'd1,
      MODE_LOOKUP    = 3'd2,
      MODE_TICK      = 3'd3,
      MODE_CLEANUP   = 3'd4
   } mode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] ip_high;
      logic [63:0] ip_low;
      logic [47:0] mac_addr;
      logic        mac_present;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic [47:0] mac_out;
      logic [63:0] ip_high_out;
      logic [63:0] ip_low_out;
      logic [4:0]  entry_count;
   } rsp_word_type;

endpackage

// ----- rtl/neighbor_cache_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor cache table
// IPv6-to-MAC neighbor cache with insertion order, searches and aging purge.
// ----------------------------------------------------------------------------
// Channel  Ports                          Direction
// request  req_valid, req_stall, req_word input word, block drives stall
// response rsp_valid, rsp_stall, rsp_word output word, block reads stall
// config   csr_wr_en, csr_wr_data         max_age write
//
// Searches and purges visit one entry at a time through the single RAM
// read port, each entry passing through a read state and a check state.
// The RAM has no reset; only data read from entries below the fill count
// is used. A stalled response holds and the next request waits for it.
// ----------------------------------------------------------------------------
module neighbor_cache_table #(
   parameter int TABLE_DEPTH = nct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nct_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nct_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);
   import nct_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [31:0] sec_ff, sec_in;
   logic [15:0] max_age_ff;

   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [ENTRY_W-1:0] ram_wd, ram_rd;
   logic [63:0] e_iph, e_ipl;
   logic [47:0] e_mac;
   logic [31:0] e_stamp, age;
   logic hit, keep;
   logic [AW-1:0] cur;

   nct_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign {e_iph, e_ipl, e_mac, e_stamp} = ram_rd;
   assign age  = sec_ff - e_stamp;
   assign keep = !(age > {16'd0, max_age_ff});
   assign cur  = rd_ff[AW-1:0] - AW'(1);
   assign hit  = (req_ff.mode == MODE_SET_BY_IP) ?
                 (e_iph == req_ff.ip_high && e_ipl == req_ff.ip_low) :
                 (e_mac == req_ff.mac_addr);
   assign ram_ra = (req_ff.mode == MODE_CLEANUP) ? rd_ff[AW-1:0] : cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         sec_ff       <= '0;
         max_age_ff   <= MAX_AGE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         sec_ff       <= sec_in;
         if (csr_wr_en) begin
            max_age_ff <= csr_wr_data;
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      rd_ff  <= rd_in;
      wr_ff  <= wr_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            case (req_ff.mode)
               MODE_SET_BY_IP, MODE_LOOKUP:
                  state_in = (rd_ff == '0) ? S_DONE : S_CHECK;
               MODE_CLEANUP: state_in = (rd_ff == fill_ff) ? S_DONE : S_CHECK;
               MODE_ADD:     state_in = S_WRITE;
               default:      state_in = S_DONE;
            endcase
         end
         S_CHECK: begin
            if (req_ff.mode == MODE_CLEANUP) begin
               state_in = S_READ;
            end else begin
               state_in = hit ? S_WRITE : S_READ;
            end
         end
         S_WRITE: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fill_in      = fill_ff;
      sec_in       = sec_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      ram_we       = 1'b0;
      ram_wa       = cur;
      ram_wd       = {e_iph, e_ipl, e_mac, sec_ff};
      req_stall    = !(state_ff == S_IDLE && !rsp_valid_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_word;
               rsp_in = '0;
               rd_in  = (req_word.mode == MODE_CLEANUP) ? '0 : fill_ff;
               wr_in  = '0;
               if (req_word.mode == MODE_SET_BY_IP || req_word.mode == MODE_LOOKUP) begin
                  rsp_in.status = ST_MISS;
               end
            end
         end
         S_READ: begin
            if (req_ff.mode == MODE_TICK) begin
               sec_in = sec_ff + 32'd1;
            end else if (req_ff.mode == MODE_CLEANUP && rd_ff == fill_ff) begin
               fill_in = wr_ff;
            end
         end
         S_CHECK: begin
            if (req_ff.mode == MODE_CLEANUP) begin
               rd_in = rd_ff + CW'(1);
               if (keep) begin
                  ram_we = 1'b1;
                  ram_wa = wr_ff[AW-1:0];
                  ram_wd = ram_rd;
                  wr_in  = wr_ff + CW'(1);
               end
            end else if (!hit) begin
               rd_in = rd_ff - CW'(1);
            end
         end
         S_WRITE: begin
            ram_we = 1'b1;
            if (req_ff.mode == MODE_ADD) begin
               if (fill_ff < CW'(TABLE_DEPTH)) begin
                  ram_wa = fill_ff[AW-1:0];
                  ram_wd = {req_ff.ip_high, req_ff.ip_low, req_ff.mac_addr, sec_ff};
                  rsp_in.entry_index = 4'(fill_ff);
                  fill_in = fill_ff + CW'(1);
               end else begin
                  ram_we = 1'b0;
                  rsp_in.status = ST_FULL;
               end
            end else begin
               rsp_in.status = ST_OK;
               rsp_in.entry_index = 4'(cur);
               if (req_ff.mode == MODE_SET_BY_IP) begin
                  if (req_ff.mac_present && req_ff.mac_addr != '0) begin
                     ram_wd = {e_iph, e_ipl, req_ff.mac_addr, sec_ff};
                     rsp_in.mac_out = req_ff.mac_addr;
                  end else begin
                     rsp_in.mac_out = e_mac;
                  end
               end else begin
                  rsp_in.ip_high_out = e_iph;
                  rsp_in.ip_low_out  = e_ipl;
               end
            end
         end
         S_DONE: begin
            rsp_in.entry_count = 5'(fill_ff);
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule

// ----- rtl/nct_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor cache table RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module nct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/nct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor cache table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module nct_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input nct_pkg::rsp_word_type rsp_word
);
   import nct_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response waits");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != 2'd3 && rsp_word.entry_count <= 5'd16)
      else $error("response status or count out of range");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back accept");
endmodule

bind neighbor_cache_table nct_checker u_nct_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
);

// ----- tb/neighbor_cache_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor cache table testbench
// Drives request words through a queue-fed driver, predicts each response
// with an independent model of the table and compares every field.
// ----------------------------------------------------------------------------
module neighbor_cache_table_test;
   import nct_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   neighbor_cache_table #(.TABLE_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   logic [63:0] tbl_iph [DEPTH];
   logic [63:0] tbl_ipl [DEPTH];
   logic [47:0] tbl_mac [DEPTH];
   logic [31:0] tbl_stamp [DEPTH];
   int unsigned tbl_fill;
   logic [31:0] tbl_seconds;
   logic [15:0] tbl_max_age;

   req_word_type pending_words[$];
   rsp_word_type expected_rsps[$];
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_cycles;
   int mismatches;
   bit timed_out;

   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type r;
      int unsigned wr;
      r = '0;
      case (w.mode)
         MODE_SET_BY_IP: begin
            r.status = ST_MISS;
            for (int e = int'(tbl_fill) - 1; e >= 0; e--) begin
               if (tbl_iph[e] == w.ip_high && tbl_ipl[e] == w.ip_low) begin
                  if (w.mac_present && w.mac_addr != 0) tbl_mac[e] = w.mac_addr;
                  tbl_stamp[e] = tbl_seconds;
                  r.mac_out = tbl_mac[e];
                  r.entry_index = e[3:0];
                  r.status = ST_OK;
                  break;
               end
            end
         end
         MODE_ADD: begin
            if (tbl_fill < DEPTH) begin
               tbl_iph[tbl_fill] = w.ip_high;
               tbl_ipl[tbl_fill] = w.ip_low;
               tbl_mac[tbl_fill] = w.mac_addr;
               tbl_stamp[tbl_fill] = tbl_seconds;
               r.entry_index = tbl_fill[3:0];
               tbl_fill++;
            end else begin
               r.status = ST_FULL;
            end
         end
         MODE_LOOKUP: begin
            r.status = ST_MISS;
            for (int e = int'(tbl_fill) - 1; e >= 0; e--) begin
               if (tbl_mac[e] == w.mac_addr) begin
                  r.ip_high_out = tbl_iph[e];
                  r.ip_low_out = tbl_ipl[e];
                  tbl_stamp[e] = tbl_seconds;
                  r.entry_index = e[3:0];
                  r.status = ST_OK;
                  break;
               end
            end
         end
         MODE_TICK: tbl_seconds++;
         MODE_CLEANUP: begin
            wr = 0;
            for (int unsigned rd = 0; rd < tbl_fill; rd++) begin
               if (32'(tbl_seconds - tbl_stamp[rd]) <= {16'd0, tbl_max_age}) begin
                  tbl_iph[wr] = tbl_iph[rd];
                  tbl_ipl[wr] = tbl_ipl[rd];
                  tbl_mac[wr] = tbl_mac[rd];
                  tbl_stamp[wr] = tbl_stamp[rd];
                  wr++;
               end
            end
            tbl_fill = wr;
         end
         default: ;
      endcase
      r.entry_count = tbl_fill[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) expected_rsps.push_back(predict_rsp(req_word));
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_word);
         end else begin
            rsp_word_type exp_rsp;
            exp_rsp = expected_rsps.pop_front();
            if (rsp_word !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", exp_rsp, rsp_word);
            end
         end
      end
   end

   function automatic req_word_type make_word(mode_type m, logic [63:0] iph,
                                              logic [63:0] ipl, logic [47:0] mac,
                                              logic present);
      req_word_type w;
      w.mode = m;
      w.ip_high = iph;
      w.ip_low = ipl;
      w.mac_addr = mac;
      w.mac_present = present;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_max_age(logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      tbl_max_age = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random words drawn from a small pool of known addresses so that
   // searches hit, with fully random addresses mixed in.
   task automatic queue_random(int count);
      logic [63:0] pool_h [4];
      logic [63:0] pool_l [4];
      logic [47:0] pool_m [4];
      req_word_type w;
      int p;
      for (int i = 0; i < 4; i++) begin
         pool_h[i] = rand64();
         pool_l[i] = rand64();
         pool_m[i] = 48'({$urandom, $urandom});
      end
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(3);
         w = make_word(mode_type'($urandom_range(4)), pool_h[p], pool_l[p], pool_m[p],
                       1'($urandom));
         if ($urandom_range(9) == 0) w.mode = mode_type'($urandom_range(7, 5));
         if ($urandom_range(5) == 0) begin
            w.ip_high = rand64();
            w.ip_low = rand64();
            w.mac_addr = 48'({$urandom, $urandom});
         end
         if ($urandom_range(7) == 0) w.mac_addr = '0;
         if (w.mode == MODE_TICK && $urandom_range(1)) begin
            repeat ($urandom_range(3)) pending_words.push_back(w);
         end
         pending_words.push_back(w);
      end
   endtask

   initial begin
      logic [47:0] ones_mac;
      ones_mac = '1;
      mismatches = 0;
      hold_cycles = 0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      tbl_fill = 0;
      tbl_seconds = '0;
      tbl_max_age = MAX_AGE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_max_age(16'd3);
      pending_words.push_back(make_word(MODE_SET_BY_IP, '1, '1, ones_mac, 1'b1));
      pending_words.push_back(make_word(MODE_LOOKUP, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_ADD, '1, '1, ones_mac, 1'b1));
      pending_words.push_back(make_word(MODE_ADD, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_ADD, '1, '1, 48'h1234, 1'b0));
      pending_words.push_back(make_word(MODE_SET_BY_IP, '1, '1, '0, 1'b1));
      pending_words.push_back(make_word(MODE_SET_BY_IP, '1, '1, 48'h5, 1'b0));
      pending_words.push_back(make_word(MODE_SET_BY_IP, '1, '1, 48'hA5, 1'b1));
      pending_words.push_back(make_word(MODE_LOOKUP, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_LOOKUP, '1, '1, ones_mac, 1'b1));
      pending_words.push_back(make_word(mode_type'(3'd5), '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(mode_type'(3'd7), '1, '1, ones_mac, 1'b1));
      for (int i = 0; i < 4; i++)
         pending_words.push_back(make_word(MODE_TICK, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_SET_BY_IP, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_CLEANUP, '0, '0, '0, 1'b0));
      for (int i = 0; i < 16; i++)
         pending_words.push_back(make_word(MODE_ADD, rand64(), rand64(), 48'(i), 1'b0));
      pending_words.push_back(make_word(MODE_ADD, '1, '0, ones_mac, 1'b0));
      wait_drained();
      write_max_age(16'd0);
      pending_words.push_back(make_word(MODE_TICK, '0, '0, '0, 1'b0));
      pending_words.push_back(make_word(MODE_CLEANUP, '0, '0, '0, 1'b0));
      wait_drained();

      write_max_age(16'd20);
      sender_idle_pct = 13;
      receiver_idle_pct = 75;
      queue_random(150);
      wait_drained();

      write_max_age(16'hFFFF);
      sender_idle_pct = 75;
      receiver_idle_pct = 13;
      queue_random(130);
      wait_drained();

      write_max_age(16'd8);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      queue_random(30);
      hold_cycles = 300;
      queue_random(110);
      wait_drained();

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("[neighbor_cache_table] OK");
      end else begin
         $display("[neighbor_cache_table] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[neighbor_cache_table] ERROR");
      $finish;
   end

endmodule
